// ----- hdl/gts_pkg.sv -----
package gts_pkg;

    localparam int DENSITIES = 256;
    localparam int FEAT_MAX  = 64;
    localparam int TOPN_MAX  = 8;

    localparam int CW_W   = $clog2(DENSITIES);
    localparam int DIM_W  = $clog2(FEAT_MAX);
    localparam int SLOT_W = $clog2(TOPN_MAX);
    localparam int N_W    = $clog2(TOPN_MAX + 1);
    localparam int FL_W   = 7;
    localparam int DC_W   = 9;
    localparam int TN_W   = 4;
    localparam int CFG_W  = 9;

    // command queue between front and back
    localparam int QD   = 4;
    localparam int QD_W = $clog2(QD);

    localparam logic [19:0]        SCALE_K = 20'd1000000;
    localparam logic signed [20:0] SCALE_S = 21'sd1000000;

    // ceil(2^52 / 1e6): exact quotient for any 32-bit partial dividend
    localparam logic [32:0] DIV_MAGIC  = 33'd4503599628;
    localparam int          DIV_DIGITS = 6;

    typedef enum logic [1:0] {
        CFG_TOPN  = 2'd0,
        CFG_FEAT  = 2'd1,
        CFG_DENS  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_MEAN = 3'd0,
        OP_DET  = 3'd1,
        OP_OBS  = 3'd2,
        OP_SLOT = 3'd3,
        OP_EVAL = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]         func;
        logic [7:0]         codeword;
        logic [5:0]         dimension;
        logic [2:0]         slot;
        logic signed [31:0] mean;
        logic [30:0]        inv_var;
        logic signed [31:0] det;
        logic signed [31:0] obs;
        logic signed [31:0] score;
    } t_item;

    typedef struct packed {
        logic [2:0]         out_slot;
        logic [7:0]         out_codeword;
        logic signed [31:0] out_score;
        logic               last;
    } t_res;

    typedef struct packed {
        t_op                op;
        logic [7:0]         codeword;
        logic [5:0]         dimension;
        logic [2:0]         slot;
        logic signed [31:0] data;
        logic [30:0]        inv_var;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CW_RD,
        ST_CW_INIT,
        ST_CHK,
        ST_RD,
        ST_SQ,
        ST_M1,
        ST_M2,
        ST_ACC,
        ST_DIV,
        ST_FDIV,
        ST_INS,
        ST_EMIT
    } t_state;

endpackage

// ----- hdl/gts_front.sv -----
module gts_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    input  gts_pkg::t_item i_item,
    output logic          full,
    output logic          o_cmd_valid,
    output gts_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import gts_pkg::*;

    t_cmd            r_q [QD];
    logic [QD_W-1:0] r_wp, r_rp;
    logic [QD_W:0]   r_cnt;
    t_cmd            cmd;
    logic            keep;
    logic            wr, rd;

    // decode and range check; dead items never reach the back end
    always_comb begin
        cmd.op        = OP_EVAL;
        cmd.codeword  = i_item.codeword;
        cmd.dimension = i_item.dimension;
        cmd.slot      = i_item.slot;
        cmd.inv_var   = i_item.inv_var;
        cmd.data      = i_item.mean;
        keep          = 1'b0;
        unique case (i_item.func)
            OP_MEAN: begin
                cmd.op = OP_MEAN;
                keep   = (int'(i_item.codeword) < DENSITIES)
                      && (int'(i_item.dimension) < FEAT_MAX);
            end
            OP_DET: begin
                cmd.op   = OP_DET;
                cmd.data = i_item.det;
                keep     = int'(i_item.codeword) < DENSITIES;
            end
            OP_OBS: begin
                cmd.op   = OP_OBS;
                cmd.data = i_item.obs;
                keep     = int'(i_item.dimension) < FEAT_MAX;
            end
            OP_SLOT: begin
                cmd.op   = OP_SLOT;
                cmd.data = i_item.score;
                keep     = int'(i_item.slot) < TOPN_MAX;
            end
            OP_EVAL: begin
                cmd.op = OP_EVAL;
                keep   = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign full        = (r_cnt == (QD_W+1)'(QD));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = push && !full && keep;
    assign rd          = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + QD_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + QD_W'(1);
            end
            r_cnt <= r_cnt + (QD_W+1)'(wr) - (QD_W+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// ----- hdl/gts_div.sv -----
module gts_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    output logic        o_busy,
    output logic [63:0] o_quot
);
    import gts_pkg::*;

    logic [59:0] r_num;
    logic [31:0] r_v;
    logic [64:0] r_prod;
    logic [63:0] r_quot;
    logic [2:0]  r_cnt;
    logic        r_phase;
    logic        r_busy;
    logic [11:0] qd;
    logic [31:0] qd_k;
    logic [19:0] rem;

    // divide by the scale constant twelve bits at a time: a reciprocal
    // multiply into r_prod, then the remainder update from that product
    assign qd     = r_prod[63:52];
    assign qd_k   = 32'(qd) * 32'(SCALE_K);
    assign rem    = 20'(r_v - qd_k);
    assign o_busy = r_busy;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cnt   <= '0;
            r_phase <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_cnt   <= 3'(DIV_DIGITS - 1);
            r_phase <= 1'b0;
        end else if (r_busy) begin
            r_phase <= !r_phase;
            if (r_phase) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_num[59:0];
            r_v    <= {28'd0, i_num[63:60]};
            r_quot <= '0;
        end else if (r_busy) begin
            if (!r_phase) begin
                r_prod <= {33'd0, r_v} * {32'd0, DIV_MAGIC};
            end else begin
                r_quot <= {r_quot[51:0], qd};
                r_v    <= {rem, r_num[59:48]};
                r_num  <= {r_num[47:0], 12'd0};
            end
        end
    end

endmodule

// ----- hdl/gts_back.sv -----
module gts_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_addr,
    input  logic [8:0]     i_cfg_data,
    input  logic           i_cmd_valid,
    input  gts_pkg::t_cmd  i_cmd,
    output logic           o_cmd_pop,
    output logic           empty,
    input  logic           pop,
    output gts_pkg::t_res  o_res
);
    import gts_pkg::*;

    // configuration
    logic [TN_W-1:0] r_cfg_tn;
    logic [FL_W-1:0] r_cfg_fl;
    logic [DC_W-1:0] r_cfg_dc;

    // tables
    logic signed [31:0] mem_mean [DENSITIES*FEAT_MAX];
    logic [30:0]        mem_ivar [DENSITIES*FEAT_MAX];
    logic signed [31:0] mem_det  [DENSITIES];
    logic signed [31:0] mem_obs  [FEAT_MAX];
    logic signed [31:0] r_mean_q, r_det_q, r_obs_q;
    logic [30:0]        r_ivar_q;

    // top-n list
    logic [7:0]         r_list_cw [TOPN_MAX];
    logic signed [31:0] r_list_sc [TOPN_MAX];
    logic [7:0]         n_list_cw [TOPN_MAX];
    logic signed [31:0] n_list_sc [TOPN_MAX];

    t_state          r_state, n_state;
    logic [N_W-1:0]  r_n;
    logic [FL_W-1:0] r_fl;
    logic [DC_W-1:0] r_dc;
    logic [DC_W-1:0] r_cw;
    logic [FL_W-1:0] r_j;
    logic [SLOT_W-1:0] r_idx;
    logic signed [63:0] r_d, r_th;
    logic [31:0]     r_mag;
    logic [63:0]     r_p, r_t1;
    logic [31:0]     r_t2;
    logic            r_neg;
    logic            r_out_valid;
    t_res            r_out;

    logic [DC_W-1:0]   cw_inc;
    logic              ge, chk_here, at_end, drop, dup;
    logic              div_start, div_busy;
    logic [63:0]       div_num, div_quot;
    logic signed [31:0] new_score, worst;
    logic [N_W-1:0]    ins_pos;
    logic [N_W-1:0]    n_sat;
    logic [FL_W-1:0]   fl_sat;
    logic [DC_W-1:0]   dc_sat;
    logic              cmd_take, out_load, out_free;
    logic              we_mean, we_det, we_obs, we_slot;
    logic              rd_tab, rd_det;
    logic signed [52:0] det_prod, th_prod;
    logic [31:0]       diff;

    gts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    // register limits as the list, vector and codeword scan see them
    assign n_sat  = (r_cfg_tn == '0) ? N_W'(1)
                  : ((int'(r_cfg_tn) > TOPN_MAX) ? N_W'(TOPN_MAX) : N_W'(r_cfg_tn));
    assign fl_sat = (int'(r_cfg_fl) > FEAT_MAX) ? FL_W'(FEAT_MAX) : r_cfg_fl;
    assign dc_sat = (int'(r_cfg_dc) > DENSITIES) ? DC_W'(DENSITIES) : r_cfg_dc;

    assign cw_inc   = r_cw + DC_W'(1);
    assign ge       = r_d >= r_th;
    assign at_end   = r_j >= r_fl;
    // test before each leading odd dimension, then once per group of four
    assign chk_here = at_end || (r_j < FL_W'(r_fl[1:0])) || (r_j[1:0] == r_fl[1:0]);
    assign drop     = chk_here && !ge;
    assign worst    = r_list_sc[SLOT_W'(r_n - N_W'(1))];
    assign det_prod = r_det_q * SCALE_S;
    assign th_prod  = worst * SCALE_S;
    assign diff     = r_obs_q - r_mean_q;
    assign new_score = r_neg ? -div_quot[31:0] : div_quot[31:0];
    assign out_free = !r_out_valid || pop;

    always_comb begin
        dup = 1'b0;
        for (int i = 0; i < TOPN_MAX; i++) begin
            if ((N_W'(i) < r_n) && (r_list_cw[i] == r_cw[CW_W-1:0])) begin
                dup = 1'b1;
            end
        end
    end

    // insertion: walk up from the bottom while the new score is not below
    always_comb begin
        ins_pos = '0;
        for (int k = 0; k < TOPN_MAX; k++) begin
            if ((N_W'(k + 1) < r_n) && (new_score < r_list_sc[k])) begin
                ins_pos = N_W'(k + 1);
            end
        end
        for (int i = 0; i < TOPN_MAX; i++) begin
            n_list_cw[i] = r_list_cw[i];
            n_list_sc[i] = r_list_sc[i];
            if (N_W'(i) == ins_pos) begin
                n_list_cw[i] = r_cw[CW_W-1:0];
                n_list_sc[i] = new_score;
            end else if ((i > 0) && (N_W'(i) > ins_pos) && (N_W'(i) < r_n)) begin
                n_list_cw[i] = r_list_cw[(i > 0) ? i - 1 : 0];
                n_list_sc[i] = r_list_sc[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        cmd_take  = 1'b0;
        we_mean   = 1'b0;
        we_det    = 1'b0;
        we_obs    = 1'b0;
        we_slot   = 1'b0;
        rd_tab    = 1'b0;
        rd_det    = 1'b0;
        div_start = 1'b0;
        div_num   = r_t1 + {r_t2, 32'h0};
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    cmd_take = 1'b1;
                    unique case (i_cmd.op)
                        OP_MEAN: we_mean = 1'b1;
                        OP_DET:  we_det  = 1'b1;
                        OP_OBS:  we_obs  = 1'b1;
                        OP_SLOT: we_slot = 1'b1;
                        OP_EVAL: n_state = (dc_sat == '0) ? ST_EMIT : ST_CW_RD;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CW_RD: begin
                rd_det  = 1'b1;
                n_state = ST_CW_INIT;
            end
            ST_CW_INIT: n_state = ST_CHK;
            ST_CHK: begin
                priority if (drop || (at_end && dup)) begin
                    n_state = (cw_inc == r_dc) ? ST_EMIT : ST_CW_RD;
                end else if (!at_end) begin
                    rd_tab  = 1'b1;
                    n_state = ST_RD;
                end else begin
                    div_start = 1'b1;
                    div_num   = r_d[63] ? 64'(-r_d) : 64'(r_d);
                    n_state   = ST_FDIV;
                end
            end
            ST_RD:  n_state = ST_SQ;
            ST_SQ:  n_state = ST_M1;
            ST_M1:  n_state = ST_M2;
            ST_M2:  n_state = ST_ACC;
            ST_ACC: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    n_state = ST_CHK;
                end
            end
            ST_FDIV: begin
                if (!div_busy) begin
                    n_state = ST_INS;
                end
            end
            ST_INS: n_state = (cw_inc == r_dc) ? ST_EMIT : ST_CW_RD;
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (N_W'(r_idx) == r_n - N_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_cmd_pop = cmd_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cfg_tn    <= TN_W'(4);
            r_cfg_fl    <= FL_W'(39);
            r_cfg_dc    <= DC_W'(256);
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_TOPN: r_cfg_tn <= i_cfg_data[TN_W-1:0];
                    CFG_FEAT: r_cfg_fl <= i_cfg_data[FL_W-1:0];
                    CFG_DENS: r_cfg_dc <= i_cfg_data[DC_W-1:0];
                    default:  r_cfg_tn <= r_cfg_tn;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_n   <= n_sat;
                r_fl  <= fl_sat;
                r_dc  <= dc_sat;
                r_cw  <= '0;
                r_idx <= '0;
            end
            ST_CW_INIT: begin
                r_d  <= 64'(det_prod);
                r_th <= 64'(th_prod);
                r_j  <= '0;
            end
            ST_CHK: begin
                r_neg <= r_d[63];
                if (drop || (at_end && dup)) begin
                    r_cw <= cw_inc;
                end
            end
            ST_RD:  r_mag <= diff[31] ? -diff : diff;
            ST_SQ:  r_p   <= r_mag * r_mag;
            ST_M1:  r_t1  <= r_p[31:0] * r_ivar_q;
            ST_M2:  r_t2  <= 32'(r_p[63:32] * r_ivar_q);
            ST_DIV: begin
                if (!div_busy) begin
                    r_d <= r_d - div_quot;
                    r_j <= r_j + FL_W'(1);
                end
            end
            ST_INS: r_cw <= cw_inc;
            ST_EMIT: begin
                if (out_load) begin
                    r_idx <= r_idx + SLOT_W'(1);
                end
            end
            default: r_cw <= r_cw;
        endcase
        if (out_load) begin
            r_out.out_slot     <= r_idx;
            r_out.out_codeword <= r_list_cw[r_idx];
            r_out.out_score    <= r_list_sc[r_idx];
            r_out.last         <= (N_W'(r_idx) == r_n - N_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_slot) begin
            r_list_cw[i_cmd.slot] <= i_cmd.codeword;
            r_list_sc[i_cmd.slot] <= i_cmd.data;
        end else if (r_state == ST_INS) begin
            r_list_cw <= n_list_cw;
            r_list_sc <= n_list_sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_mean) begin
            mem_mean[{i_cmd.codeword, i_cmd.dimension}] <= i_cmd.data;
        end
        if (rd_tab) begin
            r_mean_q <= mem_mean[{r_cw[CW_W-1:0], r_j[DIM_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_mean) begin
            mem_ivar[{i_cmd.codeword, i_cmd.dimension}] <= i_cmd.inv_var;
        end
        if (rd_tab) begin
            r_ivar_q <= mem_ivar[{r_cw[CW_W-1:0], r_j[DIM_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_det) begin
            mem_det[i_cmd.codeword] <= i_cmd.data;
        end
        if (rd_det) begin
            r_det_q <= mem_det[r_cw[CW_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_obs) begin
            mem_obs[i_cmd.dimension] <= i_cmd.data;
        end
        if (rd_tab) begin
            r_obs_q <= mem_obs[r_j[DIM_W-1:0]];
        end
    end

    assign empty = !r_out_valid;
    assign o_res = r_out;

endmodule

// ----- hdl/gmm_topn_scorer.sv -----
// load items: one per cycle unless full, to a 4-entry queue; an idle back end writes them
// evaluate: each codeword is walked dimension by dimension, each term divided in gts_div,
//   and a survivor gets a final divide in gts_div before it goes into the list
// the list then leaves one entry per cycle while popped, topn_count (1..8) results in all
// reset is synchronous, active low: clears queue, sequencer and output register,
//   loads the registers with 4, 39 and 256; tables and list hold garbage until written
module gmm_topn_scorer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  gts_pkg::t_item i_item,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output gts_pkg::t_res  o_res,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_addr,
    input  logic [8:0]     i_cfg_data
);
    import gts_pkg::*;

    logic cmd_valid, cmd_pop;
    t_cmd cmd;

    gts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    gts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .empty       (empty),
        .pop         (pop),
        .o_res       (o_res)
    );

endmodule

// ----- hdl/gts_checker.sv -----
module gts_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    input  logic           full,
    input  logic           empty,
    input  logic           pop,
    input  gts_pkg::t_res  o_res
);
    import gts_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("waiting result changed");

    a_next_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_res.last) |=>
        (empty || (o_res.out_slot == 3'($past(o_res.out_slot) + 3'd1))))
        else $error("list entries out of order");

    a_first_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_res.last) |=> (empty || (o_res.out_slot == 3'd0)))
        else $error("list does not restart at slot zero");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_res.last && !push) |=> empty)
        else $error("result after end of list");

endmodule

bind gmm_topn_scorer gts_checker u_gts_checker (.*);
